// File: rtl/hpf_pkg.sv
// Shared types, constants and character helpers for the hex packet framer.
package hpf_pkg;

  // Bytes per header field, each written as two hex digits per byte.
  localparam int ID_BYTES     = 1;
  localparam int CMD_BYTES    = 1;
  localparam int LENGTH_BYTES = 1;
  localparam int ADDR_BYTES   = 4;

  localparam int ID_W   = 8 * ID_BYTES;
  localparam int CMD_W  = 8 * CMD_BYTES;
  localparam int LEN_W  = 8 * LENGTH_BYTES;
  localparam int ADDR_W = 8 * ADDR_BYTES;
  localparam int HDR_W  = ID_W + CMD_W + LEN_W + ADDR_W;

  localparam int HDR_DIGITS    = HDR_W / 4;
  localparam int TRAILER_CHARS = 4;
  localparam int IDX_W         = $clog2(HDR_DIGITS + TRAILER_CHARS + 1);

  // Item queue between front and back; depth must be a power of two.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CRC_POLY    = 8'h07;
  localparam logic [7:0] CRC_XOR_OUT = 8'h55;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_NL   = 8'h0A;

  // Input item kinds.
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_DATA_HEX_MODE = 1'b0;
  localparam logic CFG_WRITE_CMD     = 1'b1;

  // Trailer character positions.
  localparam logic [1:0] TR_CRC_HI = 2'd0;
  localparam logic [1:0] TR_CRC_LO = 2'd1;
  localparam logic [1:0] TR_SEMI   = 2'd2;
  localparam logic [1:0] TR_NL     = 2'd3;

  typedef struct packed {
    logic       data_hex_mode;
    logic [7:0] write_command_code;
  } cfg_t;

  // One unit of work for the back end: a header or a data byte.
  typedef struct packed {
    logic             is_hdr;
    logic             hex;      // data byte written as two digits
    logic             trailer;  // CRC trailer follows this item
    logic [HDR_W-1:0] word;     // header digits, or data byte in the low bits
  } job_t;

  function automatic logic [HDR_W-1:0] hdr_word(input logic [7:0] id,
                                                input logic [7:0] cmd,
                                                input logic [7:0] len,
                                                input logic [31:0] addr);
    hdr_word = {ID_W'(id), CMD_W'(cmd), LEN_W'(len), ADDR_W'(addr)};
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      hex_char = CH_ZERO + {4'd0, nib};
    end else begin
      hex_char = CH_A + {4'd0, nib} - 8'd10;
    end
  endfunction

  // One character through the MSB-first CRC-8.
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] c);
    logic [7:0] r;
    r = crc ^ c;
    for (int b = 0; b < 8; b++) begin
      if (r[7]) begin
        r = {r[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    crc8_feed = r;
  endfunction

endpackage

// File: rtl/hpf_front.sv
// Front end: accepts items, tracks the payload count, drops stray data, builds jobs.
module hpf_front (
  input  logic                clk,
  input  logic                rst,
  input  hpf_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                kind,
  input  logic [7:0]          frame_id,
  input  logic [7:0]          command,
  input  logic [7:0]          payload_length,
  input  logic [31:0]         target_address,
  input  logic [7:0]          data_byte,
  input  logic                q_full,
  output logic                push,
  output hpf_pkg::job_t       push_job
);

  logic       in_payload;
  logic [7:0] bytes_left;
  logic       accept;
  logic       go_payload;
  logic       data_ok;

  assign in_ready   = !q_full;
  assign accept     = in_valid && in_ready;
  assign go_payload = (command == cfg.write_command_code) && (payload_length != 8'd0);
  assign data_ok    = in_payload && (bytes_left != 8'd0);
  assign push       = accept && ((kind == hpf_pkg::KIND_HEADER) || data_ok);

  always_comb begin
    if (kind == hpf_pkg::KIND_HEADER) begin
      push_job.is_hdr  = 1'b1;
      push_job.hex     = 1'b1;
      push_job.trailer = !go_payload;
      push_job.word    = hpf_pkg::hdr_word(frame_id, command, payload_length,
                                           target_address);
    end else begin
      push_job.is_hdr  = 1'b0;
      push_job.hex     = cfg.data_hex_mode;
      push_job.trailer = (bytes_left == 8'd1);
      push_job.word    = hpf_pkg::HDR_W'(data_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload <= 1'b0;
      bytes_left <= 8'd0;
    end else if (accept) begin
      if (kind == hpf_pkg::KIND_HEADER) begin
        in_payload <= go_payload;
        bytes_left <= go_payload ? payload_length : 8'd0;
      end else if (data_ok) begin
        bytes_left <= bytes_left - 8'd1;
        if (bytes_left == 8'd1) begin
          in_payload <= 1'b0;
        end
      end
    end
  end

endmodule

// File: rtl/hpf_queue.sv
// Short job queue between front and back ends.
module hpf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hpf_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output hpf_pkg::job_t head
);

  hpf_pkg::job_t                 mem [hpf_pkg::Q_DEPTH];
  logic [hpf_pkg::Q_PTR_W-1:0]   wr_ptr;
  logic [hpf_pkg::Q_PTR_W-1:0]   rd_ptr;
  logic [hpf_pkg::Q_CNT_W-1:0]   count;

  assign full       = (count == hpf_pkg::Q_CNT_W'(hpf_pkg::Q_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + hpf_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + hpf_pkg::Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + hpf_pkg::Q_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - hpf_pkg::Q_CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/hpf_back.sv
// Back end: serializes jobs into characters, runs the CRC, drives the output register.
module hpf_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  hpf_pkg::job_t head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_char,
  output logic          last
);

  logic [hpf_pkg::IDX_W-1:0] idx;
  logic [hpf_pkg::IDX_W-1:0] body_len;
  logic [hpf_pkg::IDX_W-1:0] total;
  logic [hpf_pkg::IDX_W-1:0] nib_sel;
  logic [hpf_pkg::IDX_W-1:0] tpos_full;
  logic [1:0]                tpos;
  logic [hpf_pkg::HDR_W-1:0] shifted;
  logic [7:0]                crc;
  logic [7:0]                crc_base;
  logic [7:0]                crc_x;
  logic [7:0]                body_char;
  logic [7:0]                char_next;
  logic                      last_next;
  logic                      in_body;
  logic                      emit;
  logic                      job_done;

  always_comb begin
    if (head.is_hdr) begin
      body_len = hpf_pkg::IDX_W'(hpf_pkg::HDR_DIGITS);
    end else if (head.hex) begin
      body_len = hpf_pkg::IDX_W'(2);
    end else begin
      body_len = hpf_pkg::IDX_W'(1);
    end
    total     = body_len + (head.trailer ? hpf_pkg::IDX_W'(hpf_pkg::TRAILER_CHARS) : '0);
    in_body   = (idx < body_len);
    nib_sel   = body_len - hpf_pkg::IDX_W'(1) - idx;
    tpos_full = idx - body_len;
    tpos      = tpos_full[1:0];
    shifted   = head.word >> {nib_sel, 2'b00};
    crc_x     = crc ^ hpf_pkg::CRC_XOR_OUT;

    if (!head.is_hdr && !head.hex) begin
      body_char = head.word[7:0];
    end else begin
      body_char = hpf_pkg::hex_char(shifted[3:0]);
    end

    last_next = 1'b0;
    if (in_body) begin
      char_next = body_char;
    end else begin
      case (tpos)
        hpf_pkg::TR_CRC_HI: char_next = hpf_pkg::hex_char(crc_x[7:4]);
        hpf_pkg::TR_CRC_LO: char_next = hpf_pkg::hex_char(crc_x[3:0]);
        hpf_pkg::TR_SEMI:   char_next = hpf_pkg::CH_SEMI;
        hpf_pkg::TR_NL: begin
          char_next = hpf_pkg::CH_NL;
          last_next = 1'b1;
        end
        default: char_next = hpf_pkg::CH_NL;
      endcase
    end

    // A header restarts the CRC on its first character.
    crc_base = (head.is_hdr && idx == '0) ? 8'd0 : crc;
  end

  assign emit     = head_valid && (!out_valid || out_ready);
  assign job_done = (idx == total - hpf_pkg::IDX_W'(1));
  assign pop      = emit && job_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      crc       <= 8'd0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        idx       <= job_done ? '0 : idx + hpf_pkg::IDX_W'(1);
        out_valid <= 1'b1;
        if (in_body) begin
          crc <= hpf_pkg::crc8_feed(crc_base, body_char);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char <= char_next;
      last     <= last_next;
    end
  end

  a_last_is_newline: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (out_char == hpf_pkg::CH_NL))
    else $error("last flag on a character other than newline");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (idx < total))
    else $error("character index past end of job");

  a_idx_needs_job: assert property (@(posedge clk) disable iff (rst)
    (idx != '0) |-> head_valid)
    else $error("job left queue mid-serialization");

  a_pop_resets_idx: assert property (@(posedge clk) disable iff (rst)
    pop |=> (idx == '0))
    else $error("index not cleared after job completion");

endmodule

// File: rtl/hex_packet_framer_crc8_core.sv
// Top level of the ASCII hex packet framer with CRC-8 trailer.
//
//  channel  direction  handshake            payload
//  in       to block   in_valid/in_ready    kind, frame_id, command, payload_length,
//                                           target_address, data_byte
//  out      from block out_valid/out_ready  out_char, last
//  cfg      to block   cfg_we (no wait)     cfg_index, cfg_data
//
// The back end emits one character per cycle into a single output register, while
// out_ready allows it. A header item is 14 characters of output, plus 4 when the
// trailer follows at once; a data item is 2 characters in hex mode or 1 in raw
// mode, plus 4 on the last byte. Output character rate is the only throughput limit.
// A two-item queue lets the front take new items while the back serializes.
// Reset is synchronous and active high: it empties the queue, clears the
// CRC and payload count, and sets data_hex_mode = 1 and write_command_code = 1.
// Stray data items (no payload expected) are accepted and dropped.
module hex_packet_framer_crc8_core (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  frame_id,
  input  logic [7:0]  command,
  input  logic [7:0]  payload_length,
  input  logic [31:0] target_address,
  input  logic [7:0]  data_byte,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        last,
  // configuration writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  hpf_pkg::cfg_t cfg;
  hpf_pkg::job_t push_job;
  hpf_pkg::job_t head;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          head_valid;

  // Configuration registers; the user must write them only while the block is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.data_hex_mode      <= 1'b1;
      cfg.write_command_code <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        hpf_pkg::CFG_DATA_HEX_MODE: cfg.data_hex_mode      <= cfg_data[0];
        hpf_pkg::CFG_WRITE_CMD:     cfg.write_command_code <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: classify items and track the expected payload.
  hpf_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .frame_id       (frame_id),
    .command        (command),
    .payload_length (payload_length),
    .target_address (target_address),
    .data_byte      (data_byte),
    .q_full         (q_full),
    .push           (push),
    .push_job       (push_job)
  );

  // Queue decouples item intake from character output.
  hpf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back: one character per cycle while the output is not stalled, CRC over header and payload characters.
  hpf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .last       (last)
  );

endmodule
